@@ design/hmns_pkg.sv @@
// Shared types and constants for the heightmap normal smoothing block.
package hmns_pkg;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int COMP_W     = 16;

   // request field positions in req_tdata
   localparam int COL_LSB    = 0;
   localparam int ROW_LSB    = 7;
   localparam int HEIGHT_LSB = 14;
   localparam int COORD_W    = 7;

   // item kinds carried in req_tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // configuration register indexes
   localparam logic REG_COLS = 1'b0;
   localparam logic REG_ROWS = 1'b1;
   localparam logic [7:0] DIM_RESET = 8'd128;

   // fixed point constants
   localparam logic signed [15:0] ONE_Q11 = 16'sd2048;
   localparam logic signed [17:0] ONE_Q10 = 18'sd1024;
   localparam logic [33:0]        ONE_SQ  = 34'd1048576;

   // iteration counts of the shared root and divide unit
   localparam int SQ_STEPS  = 27;
   localparam int DIV_STEPS = 12;

   // neighbour fetch slots: centre, up, down, left, right, then a drain slot
   localparam logic [2:0] SLOT_C     = 3'd0;
   localparam logic [2:0] SLOT_U     = 3'd1;
   localparam logic [2:0] SLOT_D     = 3'd2;
   localparam logic [2:0] SLOT_L     = 3'd3;
   localparam logic [2:0] SLOT_R     = 3'd4;
   localparam logic [2:0] FETCH_LAST = 3'd5;

   // triangles around a vertex
   localparam logic [1:0] TRI_LU = 2'd0;
   localparam logic [1:0] TRI_LD = 2'd1;
   localparam logic [1:0] TRI_RD = 2'd2;
   localparam logic [1:0] TRI_RU = 2'd3;

   // normal components
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   // datapath commands
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_WRITE_H   = 4'd2;
   localparam logic [3:0] OP_CLEAR_POS = 4'd3;
   localparam logic [3:0] OP_FETCH     = 4'd4;
   localparam logic [3:0] OP_ACC_CLR   = 4'd5;
   localparam logic [3:0] OP_TRI_MUL   = 4'd6;
   localparam logic [3:0] OP_SQ_INIT   = 4'd7;
   localparam logic [3:0] OP_SQ_STEP   = 4'd8;
   localparam logic [3:0] OP_DIV_INIT  = 4'd9;
   localparam logic [3:0] OP_DIV_STEP  = 4'd10;
   localparam logic [3:0] OP_DIV_ACC   = 4'd11;
   localparam logic [3:0] OP_WR_ROUGH  = 4'd12;
   localparam logic [3:0] OP_WR_SMOOTH = 4'd13;
   localparam logic [3:0] OP_LOAD_OUT  = 4'd14;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] slot;
      logic [1:0] comp;
      logic [1:0] tri_sel;
      logic       pass2;
   } hmns_cmd_type;

   typedef struct packed {
      logic       item_read;
      logic       current;
      logic       out_full;
      logic       last_pos;
      logic [3:0] tri_en;
   } hmns_status_type;

endpackage

@@ design/hmns_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module hmns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hmns_dp.sv @@
// Datapath: height and normal stores, neighbour fetch, root and divide unit, sums.
module hmns_dp #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hmns_pkg::hmns_cmd_type             cmd,
   output hmns_pkg::hmns_status_type          status,
   input  logic                               csr_valid,
   input  logic                               csr_index,
   input  logic [7:0]                         csr_data,
   input  logic [hmns_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [hmns_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int AW     = $clog2(CELLS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int DIM_W  = $clog2((MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 1);
   localparam int CMP_W  = DIM_W > 8 ? DIM_W : 8;

   // Q4.11 sum of own (doubled) and neighbours, halved toward minus infinity
   function automatic logic signed [15:0] smooth_comp(
      input logic signed [15:0] own,
      input logic signed [15:0] lf,
      input logic signed [15:0] rt,
      input logic signed [15:0] up,
      input logic signed [15:0] dn,
      input logic [3:0]         en
   );
      logic signed [18:0] t;
      logic signed [17:0] half;
      t = 19'(own) + 19'(own);
      if (en[0]) t = t + 19'(lf);
      if (en[1]) t = t + 19'(rt);
      if (en[2]) t = t + 19'(up);
      if (en[3]) t = t + 19'(dn);
      half = 18'(t >>> 1);
      if (half > 18'sd32767) begin
         smooth_comp = 16'sh7fff;
      end else if (half < -18'sd32768) begin
         smooth_comp = 16'sh8000;
      end else begin
         smooth_comp = 16'(half);
      end
   endfunction

   // configuration and freshness
   logic [7:0]       cols_ff, rows_ff;
   logic             current_ff;
   logic [CMP_W-1:0] cols_eff, rows_eff, cols_x, rows_x;

   // walk position
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             last_col, last_row, has_up, has_lf;
   logic [AW-1:0]    pos_addr, fetch_addr;

   // item
   logic                item_read_ff;
   logic [6:0]          item_col_ff, item_row_ff;
   logic [15:0]         item_h_ff;
   logic                item_inside;
   logic [AW-1:0]       item_addr;

   // memories
   logic [15:0] h_rd;
   logic [47:0] rough_rd, smooth_rd, rough_word, smooth_word;

   // neighbour slots
   logic [47:0] nb_ff [5];

   // rough pass
   logic signed [15:0] h_c, h_up, h_dn, h_lf, h_rt;
   logic signed [16:0] d_up, d_dn, d_lf, d_rt;
   logic signed [17:0] p_sel, q_sel, p_ff, q_ff, c_sel;
   logic signed [35:0] p_sq, q_sq;
   logic [32:0]        pp_ff, qq_ff;
   logic [53:0]        rad, sq_op_ff;
   logic [28:0]        sq_rem_ff;
   logic [26:0]        root_ff;
   logic [30:0]        sq_rem2, sq_trial;
   logic               c_neg, neg_ff;
   logic [16:0]        c_mag;
   logic [38:0]        div_num;
   logic [26:0]        div_rem_ff;
   logic [11:0]        div_low_ff, quo_ff;
   logic [27:0]        div_t;
   logic               div_ge;
   logic signed [15:0] acc_ff [3];
   logic signed [15:0] inc;

   // smooth pass
   logic signed [15:0] sm [3];
   logic [3:0]         sm_en;

   // output register
   logic [47:0] out_ff;
   logic        out_valid_ff;

   // 0 acts as 1, above the maximum acts as the maximum
   always_comb begin
      cols_x = CMP_W'(cols_ff);
      rows_x = CMP_W'(rows_ff);
      if (cols_x == '0) begin
         cols_eff = CMP_W'(1);
      end else if (cols_x > CMP_W'(MAX_COLS)) begin
         cols_eff = CMP_W'(MAX_COLS);
      end else begin
         cols_eff = cols_x;
      end
      if (rows_x == '0) begin
         rows_eff = CMP_W'(1);
      end else if (rows_x > CMP_W'(MAX_ROWS)) begin
         rows_eff = CMP_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_x;
      end
   end

   assign last_col = (CMP_W'(col_ff) + CMP_W'(1)) == cols_eff;
   assign last_row = (CMP_W'(row_ff) + CMP_W'(1)) == rows_eff;
   assign has_up   = row_ff != '0;
   assign has_lf   = col_ff != '0;
   assign pos_addr = AW'(row_ff) * AW'(MAX_COLS) + AW'(col_ff);

   assign item_inside = (CMP_W'(item_col_ff) < cols_eff) && (CMP_W'(item_row_ff) < rows_eff);
   assign item_addr   = AW'(item_row_ff) * AW'(MAX_COLS) + AW'(item_col_ff);

   // missing neighbours read the centre; their data is masked later
   always_comb begin
      unique case (cmd.slot)
         hmns_pkg::SLOT_U: fetch_addr = has_up ? pos_addr - AW'(MAX_COLS) : pos_addr;
         hmns_pkg::SLOT_D: fetch_addr = !last_row ? pos_addr + AW'(MAX_COLS) : pos_addr;
         hmns_pkg::SLOT_L: fetch_addr = has_lf ? pos_addr - AW'(1) : pos_addr;
         hmns_pkg::SLOT_R: fetch_addr = !last_col ? pos_addr + AW'(1) : pos_addr;
         default:          fetch_addr = pos_addr;
      endcase
   end

   hmns_ram #(.WIDTH(16), .DEPTH(CELLS)) u_height (
      .clock   (clock),
      .wr_en   (cmd.op == hmns_pkg::OP_WRITE_H && item_inside),
      .wr_addr (item_addr),
      .wr_data (item_h_ff),
      .rd_addr (fetch_addr),
      .rd_data (h_rd)
   );

   hmns_ram #(.WIDTH(48), .DEPTH(CELLS)) u_rough (
      .clock   (clock),
      .wr_en   (cmd.op == hmns_pkg::OP_WR_ROUGH),
      .wr_addr (pos_addr),
      .wr_data (rough_word),
      .rd_addr (fetch_addr),
      .rd_data (rough_rd)
   );

   hmns_ram #(.WIDTH(48), .DEPTH(CELLS)) u_smooth (
      .clock   (clock),
      .wr_en   (cmd.op == hmns_pkg::OP_WR_SMOOTH),
      .wr_addr (pos_addr),
      .wr_data (smooth_word),
      .rd_addr (item_addr),
      .rd_data (smooth_rd)
   );

   // edge height differences
   assign h_c  = nb_ff[hmns_pkg::SLOT_C][15:0];
   assign h_up = nb_ff[hmns_pkg::SLOT_U][15:0];
   assign h_dn = nb_ff[hmns_pkg::SLOT_D][15:0];
   assign h_lf = nb_ff[hmns_pkg::SLOT_L][15:0];
   assign h_rt = nb_ff[hmns_pkg::SLOT_R][15:0];
   assign d_up = 17'(h_up) - 17'(h_c);
   assign d_dn = 17'(h_dn) - 17'(h_c);
   assign d_lf = 17'(h_lf) - 17'(h_c);
   assign d_rt = 17'(h_rt) - 17'(h_c);

   always_comb begin
      unique case (cmd.tri_sel)
         hmns_pkg::TRI_LU: begin
            p_sel = 18'(d_lf);
            q_sel = 18'(d_up);
         end
         hmns_pkg::TRI_LD: begin
            p_sel = 18'(d_lf);
            q_sel = -18'(d_dn);
         end
         hmns_pkg::TRI_RD: begin
            p_sel = -18'(d_rt);
            q_sel = -18'(d_dn);
         end
         default: begin
            p_sel = -18'(d_rt);
            q_sel = 18'(d_up);
         end
      endcase
   end

   assign p_sq = p_sel * p_sel;
   assign q_sq = q_sel * q_sel;
   assign rad  = {34'(pp_ff) + 34'(qq_ff) + hmns_pkg::ONE_SQ, 20'd0};

   // one root bit per step
   assign sq_rem2  = {sq_rem_ff, sq_op_ff[53:52]};
   assign sq_trial = {2'b00, root_ff, 2'b01};

   // (|c| * 2^21 + r/2) / r, one quotient bit per step
   always_comb begin
      unique case (cmd.comp)
         hmns_pkg::COMP_X: c_sel = p_ff;
         hmns_pkg::COMP_Y: c_sel = hmns_pkg::ONE_Q10;
         default:          c_sel = q_ff;
      endcase
   end
   assign c_neg   = c_sel[17];
   assign c_mag   = c_neg ? 17'(-c_sel) : 17'(c_sel);
   assign div_num = {1'b0, c_mag, 21'd0} + 39'(root_ff[26:1]);
   assign div_t   = {div_rem_ff, div_low_ff[11]};
   assign div_ge  = div_t >= {1'b0, root_ff};
   assign inc     = neg_ff ? -16'(quo_ff) : 16'(quo_ff);

   assign rough_word = {acc_ff[2], acc_ff[1], acc_ff[0]};

   assign sm_en = {!last_row, has_up, !last_col, has_lf};
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sm[k] = smooth_comp(nb_ff[hmns_pkg::SLOT_C][16*k +: 16],
                             nb_ff[hmns_pkg::SLOT_L][16*k +: 16],
                             nb_ff[hmns_pkg::SLOT_R][16*k +: 16],
                             nb_ff[hmns_pkg::SLOT_U][16*k +: 16],
                             nb_ff[hmns_pkg::SLOT_D][16*k +: 16], sm_en);
      end
      // zero sum points straight up
      if (sm[0] == '0 && sm[1] == '0 && sm[2] == '0) begin
         smooth_word = {16'd0, hmns_pkg::ONE_Q11, 16'd0};
      end else begin
         smooth_word = {sm[2], sm[1], sm[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff    <= hmns_pkg::DIM_RESET;
         rows_ff    <= hmns_pkg::DIM_RESET;
         current_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               hmns_pkg::REG_COLS: cols_ff <= csr_data;
               hmns_pkg::REG_ROWS: rows_ff <= csr_data;
            endcase
            current_ff <= 1'b0;
         end else if (cmd.op == hmns_pkg::OP_WRITE_H && item_inside) begin
            current_ff <= 1'b0;
         end else if (cmd.op == hmns_pkg::OP_WR_SMOOTH && last_col && last_row) begin
            current_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == hmns_pkg::OP_LOAD_OUT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         hmns_pkg::OP_LOAD: begin
            item_read_ff <= req_tuser == hmns_pkg::KIND_READ;
            item_col_ff  <= req_tdata[hmns_pkg::COL_LSB +: hmns_pkg::COORD_W];
            item_row_ff  <= req_tdata[hmns_pkg::ROW_LSB +: hmns_pkg::COORD_W];
            item_h_ff    <= req_tdata[hmns_pkg::HEIGHT_LSB +: hmns_pkg::COMP_W];
         end
         hmns_pkg::OP_CLEAR_POS: begin
            col_ff <= '0;
            row_ff <= '0;
         end
         hmns_pkg::OP_FETCH: begin
            if (cmd.slot != hmns_pkg::SLOT_C) begin
               nb_ff[3'(cmd.slot - 3'd1)] <= cmd.pass2 ? rough_rd : {32'd0, h_rd};
            end
         end
         hmns_pkg::OP_ACC_CLR: begin
            for (int k = 0; k < 3; k++) begin
               acc_ff[k] <= '0;
            end
         end
         hmns_pkg::OP_TRI_MUL: begin
            p_ff  <= p_sel;
            q_ff  <= q_sel;
            pp_ff <= p_sq[32:0];
            qq_ff <= q_sq[32:0];
         end
         hmns_pkg::OP_SQ_INIT: begin
            sq_op_ff  <= rad;
            sq_rem_ff <= '0;
            root_ff   <= '0;
         end
         hmns_pkg::OP_SQ_STEP: begin
            sq_op_ff <= {sq_op_ff[51:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
               sq_rem_ff <= 29'(sq_rem2 - sq_trial);
               root_ff   <= {root_ff[25:0], 1'b1};
            end else begin
               sq_rem_ff <= 29'(sq_rem2);
               root_ff   <= {root_ff[25:0], 1'b0};
            end
         end
         hmns_pkg::OP_DIV_INIT: begin
            neg_ff     <= c_neg;
            div_rem_ff <= div_num[38:12];
            div_low_ff <= div_num[11:0];
            quo_ff     <= '0;
         end
         hmns_pkg::OP_DIV_STEP: begin
            div_rem_ff <= div_ge ? 27'(div_t - {1'b0, root_ff}) : 27'(div_t);
            div_low_ff <= {div_low_ff[10:0], 1'b0};
            quo_ff     <= {quo_ff[10:0], div_ge};
         end
         hmns_pkg::OP_DIV_ACC: begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) == cmd.comp) begin
                  acc_ff[k] <= acc_ff[k] + inc;
               end
            end
         end
         hmns_pkg::OP_WR_ROUGH, hmns_pkg::OP_WR_SMOOTH: begin
            // raster step, wrapping to the origin after the last vertex
            if (last_col) begin
               col_ff <= '0;
               row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
         hmns_pkg::OP_LOAD_OUT: begin
            out_ff <= item_inside ? smooth_rd : {16'd0, hmns_pkg::ONE_Q11, 16'd0};
         end
         default: begin
         end
      endcase
   end

   assign status = '{
      item_read: item_read_ff,
      current:   current_ff,
      out_full:  out_valid_ff,
      last_pos:  last_col && last_row,
      tri_en:    {has_up && !last_col, !last_row && !last_col,
                  !last_row && has_lf, has_up && has_lf}
   };

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

@@ design/hmns_ctrl.sv @@
// Controller: sequences item handling and the two recompute passes.
module hmns_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  hmns_pkg::hmns_status_type status,
   output hmns_pkg::hmns_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_FETCH  = 4'd2;
   localparam logic [3:0] S_VCLR   = 4'd3;
   localparam logic [3:0] S_TRI    = 4'd4;
   localparam logic [3:0] S_SQI    = 4'd5;
   localparam logic [3:0] S_SQS    = 4'd6;
   localparam logic [3:0] S_DVI    = 4'd7;
   localparam logic [3:0] S_DVS    = 4'd8;
   localparam logic [3:0] S_DVA    = 4'd9;
   localparam logic [3:0] S_WRR    = 4'd10;
   localparam logic [3:0] S_SMOOTH = 4'd11;
   localparam logic [3:0] S_RD     = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [2:0] fk_ff, fk_in;
   logic [1:0] tri_ff, tri_in;
   logic [1:0] comp_ff, comp_in;
   logic [4:0] step_ff, step_in;
   logic       pass2_ff, pass2_in;
   logic [3:0] op;

   always_comb begin
      state_in = state_ff;
      fk_in    = fk_ff;
      tri_in   = tri_ff;
      comp_in  = comp_ff;
      step_in  = step_ff;
      pass2_in = pass2_ff;
      op       = hmns_pkg::OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = hmns_pkg::OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!status.item_read) begin
               op       = hmns_pkg::OP_WRITE_H;
               state_in = S_IDLE;
            end else if (status.current) begin
               state_in = S_OUT;
            end else begin
               op       = hmns_pkg::OP_CLEAR_POS;
               pass2_in = 1'b0;
               fk_in    = hmns_pkg::SLOT_C;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            op = hmns_pkg::OP_FETCH;
            if (fk_ff == hmns_pkg::FETCH_LAST) begin
               fk_in    = hmns_pkg::SLOT_C;
               state_in = pass2_ff ? S_SMOOTH : S_VCLR;
            end else begin
               fk_in = fk_ff + 3'd1;
            end
         end
         S_VCLR: begin
            op       = hmns_pkg::OP_ACC_CLR;
            tri_in   = hmns_pkg::TRI_LU;
            state_in = S_TRI;
         end
         S_TRI: begin
            if (status.tri_en[tri_ff]) begin
               op       = hmns_pkg::OP_TRI_MUL;
               state_in = S_SQI;
            end else if (tri_ff == hmns_pkg::TRI_RU) begin
               state_in = S_WRR;
            end else begin
               tri_in = tri_ff + 2'd1;
            end
         end
         S_SQI: begin
            op       = hmns_pkg::OP_SQ_INIT;
            step_in  = '0;
            state_in = S_SQS;
         end
         S_SQS: begin
            op = hmns_pkg::OP_SQ_STEP;
            if (step_ff == 5'(hmns_pkg::SQ_STEPS - 1)) begin
               comp_in  = hmns_pkg::COMP_X;
               state_in = S_DVI;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         S_DVI: begin
            op       = hmns_pkg::OP_DIV_INIT;
            step_in  = '0;
            state_in = S_DVS;
         end
         S_DVS: begin
            op = hmns_pkg::OP_DIV_STEP;
            if (step_ff == 5'(hmns_pkg::DIV_STEPS - 1)) begin
               state_in = S_DVA;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         S_DVA: begin
            op = hmns_pkg::OP_DIV_ACC;
            if (comp_ff == hmns_pkg::COMP_Z) begin
               if (tri_ff == hmns_pkg::TRI_RU) begin
                  state_in = S_WRR;
               end else begin
                  tri_in   = tri_ff + 2'd1;
                  state_in = S_TRI;
               end
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DVI;
            end
         end
         S_WRR: begin
            op       = hmns_pkg::OP_WR_ROUGH;
            state_in = S_FETCH;
            if (status.last_pos) begin
               pass2_in = 1'b1;
            end
         end
         S_SMOOTH: begin
            op       = hmns_pkg::OP_WR_SMOOTH;
            state_in = status.last_pos ? S_RD : S_FETCH;
         end
         S_RD: begin
            // smooth store read of the item's vertex is in flight
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!status.out_full) begin
               op       = hmns_pkg::OP_LOAD_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fk_ff    <= '0;
         tri_ff   <= '0;
         comp_ff  <= '0;
         step_ff  <= '0;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fk_ff    <= fk_in;
         tri_ff   <= tri_in;
         comp_ff  <= comp_in;
         step_ff  <= step_in;
         pass2_ff <= pass2_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign cmd = '{op: op, slot: fk_ff, comp: comp_ff, tri_sel: tri_ff, pass2: pass2_ff};

endmodule

@@ design/heightmap_normal_smoothing.sv @@
// Heightmap terrain normals: a write item stores one Q5.10 height at a vertex; a read
// item returns the smoothed Q4.11 normal there. Items are handled one at a time. A read
// of current normals reads the smooth store and loads the result into the output register.
// A read after an in-grid height write or any register write first recomputes the
// in-use grid in a rough pass, with up to 4 triangles at a vertex, then a smooth pass.
// The rough pass uses the shared root and divide unit, which produces one bit a cycle:
// a square root and three divides per triangle. A finished result waits in the output
// register while the next item is taken. The register port is always ready.
module heightmap_normal_smoothing #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // col[6:0], row[13:7], height[29:14], zero[31:30]
   input  logic        req_tuser,  // operation: 0 write height, 1 read normal
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // normal_x[15:0], normal_y[31:16], normal_z[47:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   hmns_pkg::hmns_cmd_type    cmd;
   hmns_pkg::hmns_status_type status;

   assign csr_ready = 1'b1;

   hmns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hmns_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/hmns_checker.sv @@
// Port-level checks for the heightmap normal block, bound to the top level.
module hmns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken before the first was handled");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !$rose(rsp_tvalid))
      else $error("result produced by a height write");

endmodule

bind heightmap_normal_smoothing hmns_checker u_hmns_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for the heightmap normal smoothing block.
class normal_scoreboard;
   shortint heights[16384];
   shortint rough[16384][3];
   shortint smooth[16384][3];
   bit current;
   int cols_reg = 128;
   int rows_reg = 128;
   longint tri_sum[3];
   logic [47:0] pending_normals[$];
   int errors;
   int results;

   function int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > 128) return 128;
      return v;
   endfunction

   function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function longint unsigned int_root(longint unsigned v);
      longint unsigned res, bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (v >= res + bit_pos) begin
            v = v - (res + bit_pos);
            res = (res >> 1) + bit_pos;
         end else begin
            res = res >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return res;
   endfunction

   // Q4.11 component, rounded half away from zero
   function longint unit_part(longint c, longint unsigned r);
      longint unsigned m;
      longint n;
      m = (c < 0) ? -c : c;
      n = ((m << 21) + r / 2) / r;
      return (c < 0) ? -n : n;
   endfunction

   function void add_triangle(longint p, longint q);
      longint unsigned s, r;
      s = p * p + q * q + (64'd1 << 20);
      r = int_root(s << 20);
      tri_sum[0] += unit_part(p, r);
      tri_sum[1] += unit_part(1024, r);
      tri_sum[2] += unit_part(q, r);
   endfunction

   function void rebuild(int cols, int rows);
      int i;
      longint h, du, dd, dl, dr, t;
      longint v[3];
      bit hu, hd, hl, hr;
      for (int row = 0; row < rows; row++) begin
         for (int col = 0; col < cols; col++) begin
            i = row * 128 + col;
            h = heights[i];
            hu = row > 0;
            hd = row + 1 < rows;
            hl = col > 0;
            hr = col + 1 < cols;
            du = hu ? heights[i - 128] - h : 0;
            dd = hd ? heights[i + 128] - h : 0;
            dl = hl ? heights[i - 1] - h : 0;
            dr = hr ? heights[i + 1] - h : 0;
            tri_sum = '{0, 0, 0};
            if (hl && hu) add_triangle(dl, du);
            if (hl && hd) add_triangle(dl, -dd);
            if (hr && hd) add_triangle(-dr, -dd);
            if (hr && hu) add_triangle(-dr, du);
            for (int k = 0; k < 3; k++) rough[i][k] = shortint'(sat16(tri_sum[k]));
         end
      end
      for (int row = 0; row < rows; row++) begin
         for (int col = 0; col < cols; col++) begin
            i = row * 128 + col;
            for (int k = 0; k < 3; k++) begin
               t = 2 * longint'(rough[i][k]);
               if (col > 0) t += rough[i - 1][k];
               if (col + 1 < cols) t += rough[i + 1][k];
               if (row > 0) t += rough[i - 128][k];
               if (row + 1 < rows) t += rough[i + 128][k];
               v[k] = sat16(t >>> 1);
            end
            if (v[0] == 0 && v[1] == 0 && v[2] == 0) v[1] = hmns_pkg::ONE_Q11;
            for (int k = 0; k < 3; k++) smooth[i][k] = shortint'(v[k]);
         end
      end
      current = 1;
   endfunction

   function void note_register(logic idx, logic [7:0] val);
      if (idx == hmns_pkg::REG_COLS) cols_reg = val;
      else rows_reg = val;
      current = 0;
   endfunction

   function void note_item(logic op, int col, int row, logic [15:0] h);
      int cols, rows, i;
      bit in_grid;
      logic [15:0] nx, ny, nz;
      cols = clamp_dim(cols_reg);
      rows = clamp_dim(rows_reg);
      in_grid = col < cols && row < rows;
      i = row * 128 + col;
      if (op == hmns_pkg::KIND_WRITE) begin
         if (in_grid) begin
            heights[i] = shortint'(h);
            current = 0;
         end
      end else begin
         if (!current) rebuild(cols, rows);
         nx = 0;
         ny = hmns_pkg::ONE_Q11;
         nz = 0;
         if (in_grid) begin
            nx = smooth[i][0];
            ny = smooth[i][1];
            nz = smooth[i][2];
         end
         pending_normals.push_back({nz, ny, nx});
      end
   endfunction

   function void check_normal(logic [47:0] got);
      logic [47:0] want;
      results++;
      if (pending_normals.size() == 0) begin
         $error("normal result with nothing expected: %h", got);
         errors++;
         return;
      end
      want = pending_normals.pop_front();
      if (got[15:0] !== want[15:0]) begin
         $error("normal_x expected %0d got %0d", $signed(want[15:0]), $signed(got[15:0]));
         errors++;
      end
      if (got[31:16] !== want[31:16]) begin
         $error("normal_y expected %0d got %0d", $signed(want[31:16]),
                $signed(got[31:16]));
         errors++;
      end
      if (got[47:32] !== want[47:32]) begin
         $error("normal_z expected %0d got %0d", $signed(want[47:32]),
                $signed(got[47:32]));
         errors++;
      end
   endfunction
endclass

module tb;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // col[6:0], row[13:7], height[29:14], zero[31:30]
   logic        req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   normal_scoreboard sb;
   bit   written[16384];
   bit   no_gaps;
   int   item_count;
   int   phase_count;
   int   idle_cycles;
   int   eff_cols, eff_rows;

   heightmap_normal_smoothing u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= hmns_pkg::KIND_WRITE;
      rsp_tready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= hmns_pkg::REG_COLS;
      csr_data <= '0;
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 300000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [15:0] pick_height();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(logic op, int col, int row, logic [15:0] h);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, h, 7'(row), 7'(col)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(op, col, row, h);
      if (op == hmns_pkg::KIND_WRITE && col < eff_cols && row < eff_rows)
         written[row * 128 + col] = 1;
      item_count++;
   endtask

   // lets the block settle, then writes both dimension registers
   task automatic set_grid(logic [7:0] cols, logic [7:0] rows);
      req_tvalid <= 1'b0;
      while (sb.pending_normals.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      for (int r = 0; r < 2; r++) begin
         csr_valid <= 1'b1;
         csr_index <= (r == 0) ? hmns_pkg::REG_COLS : hmns_pkg::REG_ROWS;
         csr_data <= (r == 0) ? cols : rows;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.note_register((r == 0) ? hmns_pkg::REG_COLS : hmns_pkg::REG_ROWS,
                          (r == 0) ? cols : rows);
      end
      csr_valid <= 1'b0;
      eff_cols = sb.clamp_dim(cols);
      eff_rows = sb.clamp_dim(rows);
      phase_count++;
      // every in-use height must exist before a recompute
      for (int row = 0; row < eff_rows; row++)
         for (int col = 0; col < eff_cols; col++)
            if (!written[row * 128 + col])
               send_item(hmns_pkg::KIND_WRITE, col, row, pick_height());
   endtask

   task automatic noise_item();
      int col, row;
      col = $urandom_range(0, 127);
      row = $urandom_range(0, 127);
      case ($urandom_range(0, 2))
         0: begin
            if (eff_cols < 128) col = $urandom_range(eff_cols, 127);
            else if (eff_rows < 128) row = $urandom_range(eff_rows, 127);
            send_item(hmns_pkg::KIND_WRITE, col, row, pick_height());
         end
         1: send_item(hmns_pkg::KIND_READ, col, row, 16'($urandom));
         default: send_item(hmns_pkg::KIND_READ, $urandom_range(0, eff_cols - 1),
                            $urandom_range(0, eff_rows - 1), 16'($urandom));
      endcase
   endtask

   task automatic run_phase(int n);
      int start;
      start = item_count;
      while (item_count - start < n) begin
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 4))
               send_item(hmns_pkg::KIND_WRITE, $urandom_range(0, eff_cols - 1),
                         $urandom_range(0, eff_rows - 1), pick_height());
            repeat ($urandom_range(1, 5))
               send_item(hmns_pkg::KIND_READ, $urandom_range(0, eff_cols - 1),
                         $urandom_range(0, eff_rows - 1), 16'($urandom));
         end else begin
            noise_item();
         end
      end
   endtask

   // receiver, with one long hold-off to back the block up
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 16);
         if (sb.results == 40) gap = 500;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_normal(rsp_tdata);
      end
   end

   initial begin
      eff_cols = 128;
      eff_rows = 128;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // corners of the full grid at reset size, writes only
      send_item(hmns_pkg::KIND_WRITE, 0, 0, 16'h7fff);
      send_item(hmns_pkg::KIND_WRITE, 127, 127, 16'h8000);
      send_item(hmns_pkg::KIND_WRITE, 127, 0, 16'h0000);
      // tiny grid with extreme slopes, outside reads and writes
      set_grid(8'd2, 8'd2);
      send_item(hmns_pkg::KIND_WRITE, 1, 1, 16'h8000);
      send_item(hmns_pkg::KIND_WRITE, 0, 1, 16'h7fff);
      send_item(hmns_pkg::KIND_WRITE, 1, 0, 16'h8000);
      for (int k = 0; k < 4; k++) send_item(hmns_pkg::KIND_READ, k % 2, k / 2, 16'hffff);
      send_item(hmns_pkg::KIND_READ, 127, 127, 16'h0000);
      send_item(hmns_pkg::KIND_WRITE, 100, 0, 16'h1234);
      send_item(hmns_pkg::KIND_READ, 0, 0, 16'h0000);
      // single vertex: no triangles, so the sum is zero and points up
      set_grid(8'd1, 8'd1);
      send_item(hmns_pkg::KIND_READ, 0, 0, 16'h0000);
      // zero acts as one, oversize acts as the maximum
      set_grid(8'd0, 8'd255);
      send_item(hmns_pkg::KIND_READ, 0, 127, 16'h0000);
      send_item(hmns_pkg::KIND_READ, 1, 5, 16'h0000);
      set_grid(8'd255, 8'd0);
      send_item(hmns_pkg::KIND_READ, 127, 0, 16'h0000);
      while (item_count < 1450) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 19))
            0: begin set_grid(8'd128, 8'd2); run_phase(6); end
            1: begin set_grid(8'd2, 8'd128); run_phase(6); end
            2: begin set_grid(8'd1, 8'd128); run_phase(20); end
            3: begin set_grid(8'd0, 8'd0); run_phase(10); end
            default: begin
               set_grid(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
               run_phase(40);
            end
         endcase
      end
      req_tvalid <= 1'b0;
      while (sb.pending_normals.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d items over %0d grid settings, %0d normals checked.",
               item_count, phase_count, sb.results);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

@@ files.f @@
design/hmns_pkg.sv
design/hmns_ram.sv
design/hmns_dp.sv
design/hmns_ctrl.sv
design/heightmap_normal_smoothing.sv
design/hmns_checker.sv
test/tb.sv
